@@ sv/blm_pkg.sv @@
// Shared types and constants for the battery level monitor.
// No dependencies; the sv files refer to it by scoped names, the test files import it.
package blm_pkg;

	localparam int unsigned DataW   = 16;
	localparam int unsigned SumW    = 18;
	localparam int unsigned CountW  = 2;
	localparam int unsigned RegIdxW = 3;
	localparam int unsigned AddrW   = 5;
	localparam int unsigned PDataW  = 32;

	// Margin under which the whole reading wins over a close estimate
	localparam logic [DataW-1:0] NearMargin = 16'd1700;

	// Four confirm samples, averaged by a shift of two
	localparam logic [CountW-1:0] LastSample   = 2'd3;
	localparam int unsigned       ConfirmShift = 2;

	typedef enum logic [RegIdxW-1:0] {
		REG_OFFSET_FULL    = 3'd0,
		REG_OFFSET_MID     = 3'd1,
		REG_LOW_THRESHOLD  = 3'd2,
		REG_STOP_THRESHOLD = 3'd3,
		REG_DISCONNECT     = 3'd4,
		REG_ALKALINE_WARN  = 3'd5,
		REG_GOOD_FULL      = 3'd6,
		REG_LITHIUM        = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		STATUS_NORMAL       = 2'd0,
		STATUS_WARNING      = 2'd1,
		STATUS_STOP         = 2'd2,
		STATUS_DISCONNECTED = 2'd3
	} status_t;

	typedef enum logic {
		REQ_SINGLE  = 1'b0,
		REQ_CONFIRM = 1'b1
	} req_t;

	typedef struct packed {
		logic [DataW-1:0] offset_full;
		logic [DataW-1:0] offset_mid;
		logic [DataW-1:0] low_threshold;
		logic [DataW-1:0] stop_threshold;
		logic [DataW-1:0] disconnect_level;
		logic [DataW-1:0] alkaline_warn_level;
		logic [DataW-1:0] good_full_level;
		logic [DataW-1:0] lithium_level;
	} cfg_t;

	// Input stage contents handed to the result stage
	typedef struct packed {
		logic             valid;
		req_t             req;
		logic [DataW-1:0] mid;
	} stage_t;

endpackage

@@ sv/blm_regs.sv @@
// APB-style configuration register file of the battery level monitor.
// Depends on blm_pkg for the register index codes and the config struct.
module blm_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [blm_pkg::AddrW-1:0]   paddr,
	input  logic [blm_pkg::PDataW-1:0]  pwdata,
	output logic [blm_pkg::PDataW-1:0]  prdata,
	output logic                        pready,
	output blm_pkg::cfg_t               cfg
);

	blm_pkg::cfg_t     cfg_q;
	blm_pkg::reg_idx_t idx;
	logic              wr_en;
	logic [blm_pkg::DataW-1:0] wdata;
	logic [blm_pkg::DataW-1:0] rdata;

	assign idx    = blm_pkg::reg_idx_t'(paddr[blm_pkg::AddrW-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign wdata  = pwdata[blm_pkg::DataW-1:0];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Write the addressed register in the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				blm_pkg::REG_OFFSET_FULL:    cfg_q.offset_full         <= wdata;
				blm_pkg::REG_OFFSET_MID:     cfg_q.offset_mid          <= wdata;
				blm_pkg::REG_LOW_THRESHOLD:  cfg_q.low_threshold       <= wdata;
				blm_pkg::REG_STOP_THRESHOLD: cfg_q.stop_threshold      <= wdata;
				blm_pkg::REG_DISCONNECT:     cfg_q.disconnect_level    <= wdata;
				blm_pkg::REG_ALKALINE_WARN:  cfg_q.alkaline_warn_level <= wdata;
				blm_pkg::REG_GOOD_FULL:      cfg_q.good_full_level     <= wdata;
				blm_pkg::REG_LITHIUM:        cfg_q.lithium_level       <= wdata;
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		unique case (idx)
			blm_pkg::REG_OFFSET_FULL:    rdata = cfg_q.offset_full;
			blm_pkg::REG_OFFSET_MID:     rdata = cfg_q.offset_mid;
			blm_pkg::REG_LOW_THRESHOLD:  rdata = cfg_q.low_threshold;
			blm_pkg::REG_STOP_THRESHOLD: rdata = cfg_q.stop_threshold;
			blm_pkg::REG_DISCONNECT:     rdata = cfg_q.disconnect_level;
			blm_pkg::REG_ALKALINE_WARN:  rdata = cfg_q.alkaline_warn_level;
			blm_pkg::REG_GOOD_FULL:      rdata = cfg_q.good_full_level;
			blm_pkg::REG_LITHIUM:        rdata = cfg_q.lithium_level;
			default:                     rdata = '0;
		endcase
	end

	assign prdata = {{(blm_pkg::PDataW - blm_pkg::DataW){1'b0}}, rdata};

endmodule

@@ sv/blm_estimate.sv @@
// Equivalent battery voltage from the whole and mid readings (combinational).
// Depends on blm_pkg for the config struct and the near margin.
module blm_estimate (
	input  blm_pkg::cfg_t               cfg,
	input  logic [blm_pkg::DataW-1:0]   whole,
	input  logic [blm_pkg::DataW-1:0]   mid,
	output logic [blm_pkg::DataW-1:0]   voltage
);

	localparam int unsigned EstW    = blm_pkg::DataW + 2;
	localparam int unsigned MarginW = EstW + 1;

	logic [blm_pkg::DataW-1:0] w, m, t;
	logic [blm_pkg::DataW-1:0] big, little, half, weakest;
	logic [EstW-1:0]           est;
	logic [MarginW-1:0]        est_margin;

	// Offset both readings and form the difference
	assign w = whole + cfg.offset_full;
	assign m = mid + cfg.offset_mid;
	assign t = w - m;

	// Weakest cell: take the smaller part against half of the larger one
	always_comb begin
		if (t > m) begin
			big    = t;
			little = m;
		end else begin
			big    = m;
			little = t;
		end
		half    = big >> 1;
		weakest = (little > half) ? (little - half) : (little >> 1);
	end

	assign est        = {weakest, 2'b00};
	assign est_margin = {1'b0, est} + MarginW'(blm_pkg::NearMargin);

	// Pick the voltage: raw, offset whole, zero, or the clamped estimate
	always_comb begin
		if (whole < cfg.disconnect_level) begin
			voltage = whole;
		end else if (mid <= cfg.disconnect_level) begin
			voltage = w;
		end else if (w < m) begin
			voltage = '0;
		end else if (m < cfg.disconnect_level) begin
			voltage = w;
		end else if (est > {2'b00, w}) begin
			voltage = w;
		end else if (est <= {2'b00, cfg.alkaline_warn_level}
				&& est_margin > {3'b000, w}) begin
			voltage = w;
		end else begin
			voltage = est[blm_pkg::DataW-1:0];
		end
	end

endmodule

@@ sv/blm_result.sv @@
// Result stage: grading, confirm averaging and the output register.
// Depends on blm_pkg for status and request codes and shared structs.
module blm_result (
	input  logic                        clk,
	input  logic                        arst_n,
	input  blm_pkg::cfg_t               cfg,
	input  blm_pkg::stage_t             stage,
	input  logic [blm_pkg::DataW-1:0]   est_voltage,
	output logic                        take,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [blm_pkg::DataW-1:0]   voltage,
	output logic [1:0]                  status,
	output logic                        is_lithium,
	output logic                        non_full
);

	logic                        out_valid_q;
	logic [blm_pkg::SumW-1:0]    sum_q, sum_next;
	logic [blm_pkg::CountW-1:0]  count_q;
	logic [blm_pkg::DataW-1:0]   voltage_q, avg, res_voltage;
	blm_pkg::status_t            status_q, res_status, grade_v, grade_avg;
	logic                        is_lithium_q, non_full_q, res_lithium, res_non_full;
	logic                        last, emits, slot_free, confirm;

	assign confirm   = (stage.req == blm_pkg::REQ_CONFIRM);
	assign last      = (count_q == blm_pkg::LastSample);
	assign emits     = !confirm || last;
	assign slot_free = !out_valid_q || out_ready;
	assign take      = stage.valid && (!emits || slot_free);

	assign sum_next = sum_q + {{(blm_pkg::SumW - blm_pkg::DataW){1'b0}}, est_voltage};
	assign avg      = sum_next[blm_pkg::ConfirmShift +: blm_pkg::DataW];

	// Three-level grade of a voltage
	function automatic blm_pkg::status_t grade(
		input logic [blm_pkg::DataW-1:0] v,
		input logic [blm_pkg::DataW-1:0] low,
		input logic [blm_pkg::DataW-1:0] stop
	);
		if (v > low)
			return blm_pkg::STATUS_NORMAL;
		else if (v > stop)
			return blm_pkg::STATUS_WARNING;
		else
			return blm_pkg::STATUS_STOP;
	endfunction

	assign grade_v   = grade(est_voltage, cfg.low_threshold, cfg.stop_threshold);
	assign grade_avg = grade(avg, cfg.low_threshold, cfg.stop_threshold);

	// Form the result fields for either request kind
	always_comb begin
		if (confirm) begin
			res_voltage  = avg;
			res_status   = grade_avg;
			res_lithium  = 1'b0;
			res_non_full = 1'b0;
		end else begin
			res_voltage = est_voltage;
			if (grade_v == blm_pkg::STATUS_STOP && est_voltage <= cfg.disconnect_level)
				res_status = blm_pkg::STATUS_DISCONNECTED;
			else
				res_status = grade_v;
			res_lithium  = (est_voltage >= cfg.lithium_level);
			res_non_full = (est_voltage <= cfg.good_full_level)
				&& (stage.mid > cfg.disconnect_level);
		end
	end

	// Output valid and confirm accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sum_q       <= '0;
			count_q     <= '0;
		end else begin
			if (take && emits)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (take && confirm) begin
				if (last) begin
					sum_q   <= '0;
					count_q <= '0;
				end else begin
					sum_q   <= sum_next;
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	// Result payload, loaded with each emitted item
	always_ff @(posedge clk) begin
		if (take && emits) begin
			voltage_q    <= res_voltage;
			status_q     <= res_status;
			is_lithium_q <= res_lithium;
			non_full_q   <= res_non_full;
		end
	end

	assign out_valid  = out_valid_q;
	assign voltage    = voltage_q;
	assign status     = status_q;
	assign is_lithium = is_lithium_q;
	assign non_full   = non_full_q;

endmodule

@@ sv/battery_level_monitor.sv @@
// Battery level monitor: grades the battery stack from a pair of ADC readings.
//
// Input channel (in_valid/in_ready): one item carries req_type, whole_reading
// and mid_reading. Output channel (out_valid/out_ready): voltage, status,
// is_lithium and non_full. Configuration goes through the APB-style port,
// one 16-bit register every 4 bytes; pready is always high.
//
// A single request (req_type 0) gives one result. Confirm requests
// (req_type 1) add up; the fourth gives the average and the next three give
// nothing. Single requests in between leave the running average alone.
//
// A result passes the input register, then the result register, on its way
// to the output. Throughput: one item per cycle while the receiver does not
// stall, set by the combinational estimate between the two registers.
// When the receiver stalls, the result holds and the input register still
// takes one more item; confirm items that give no result keep flowing.
// Reset clears the config registers, the confirm sum and count, and both valids.
// Depends on blm_pkg, blm_regs, blm_estimate and blm_result.
module battery_level_monitor (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [blm_pkg::AddrW-1:0]   paddr,
	input  logic [blm_pkg::PDataW-1:0]  pwdata,
	output logic [blm_pkg::PDataW-1:0]  prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        req_type,
	input  logic [blm_pkg::DataW-1:0]   whole_reading,
	input  logic [blm_pkg::DataW-1:0]   mid_reading,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [blm_pkg::DataW-1:0]   voltage,
	output logic [1:0]                  status,
	output logic                        is_lithium,
	output logic                        non_full
);

	blm_pkg::cfg_t             cfg;
	blm_pkg::stage_t           stage;
	logic                      valid_s1;
	blm_pkg::req_t             req_s1;
	logic [blm_pkg::DataW-1:0] whole_s1, mid_s1;
	logic [blm_pkg::DataW-1:0] est_voltage;
	logic                      take, in_accept;

	blm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign in_ready  = !valid_s1 || take;
	assign in_accept = in_valid && in_ready;

	// Input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			req_s1   <= blm_pkg::req_t'(req_type);
			whole_s1 <= whole_reading;
			mid_s1   <= mid_reading;
		end
	end

	blm_estimate u_estimate (
		.cfg     (cfg),
		.whole   (whole_s1),
		.mid     (mid_s1),
		.voltage (est_voltage)
	);

	assign stage.valid = valid_s1;
	assign stage.req   = req_s1;
	assign stage.mid   = mid_s1;

	blm_result u_result (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.stage       (stage),
		.est_voltage (est_voltage),
		.take        (take),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.voltage     (voltage),
		.status      (status),
		.is_lithium  (is_lithium),
		.non_full    (non_full)
	);

endmodule

@@ sv/blm_checker.sv @@
// Port-level checks for the battery level monitor, bound to the top level.
// Depends on blm_pkg for widths; sees only the top level's ports.
module blm_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic                        req_type,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [blm_pkg::DataW-1:0]   voltage,
	input  logic [1:0]                  status,
	input  logic                        is_lithium,
	input  logic                        non_full
);

	// A stalled result holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(voltage) && $stable(status)
			&& $stable(is_lithium) && $stable(non_full))
		else $error("stalled result changed");

	// An empty output register never blocks the input
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	// A single request shows a result after the input and result registers
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !req_type |-> ##2 out_valid)
		else $error("single request result missing");

endmodule

bind battery_level_monitor blm_checker u_blm_checker (.*);

@@ test/blm_checker.sv @@
`timescale 1ns / 100ps
// Checker for the battery level monitor: mirrors register writes, predicts the
// report for each item that yields one and compares each accepted result with it.
// Depends on blm_pkg.
module blm_tb_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [blm_pkg::AddrW-1:0]   paddr,
	input  logic [blm_pkg::PDataW-1:0]  pwdata,
	input  logic                        pready,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic                        req_type,
	input  logic [blm_pkg::DataW-1:0]   whole_reading,
	input  logic [blm_pkg::DataW-1:0]   mid_reading,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [blm_pkg::DataW-1:0]   voltage,
	input  logic [1:0]                  status,
	input  logic                        is_lithium,
	input  logic                        non_full,
	output int                          pending,
	output int                          fail_count
);
	import blm_pkg::*;

	typedef struct packed {
		logic [DataW-1:0] voltage;
		status_t          status;
		logic             is_lithium;
		logic             non_full;
	} battery_report_t;

	cfg_t              cfg_mirror;
	logic [SumW-1:0]   confirm_sum;
	logic [CountW-1:0] confirm_count;
	battery_report_t   predicted_reports[$];

	// Four times the weakest cell, clamped to the offset whole; zero when w is under m
	function automatic logic [DataW-1:0] weakest_cell_estimate(input logic [DataW-1:0] w,
			input logic [DataW-1:0] m);
		logic [DataW-1:0] t;
		logic [DataW-1:0] half;
		logic [DataW-1:0] weakest;
		logic [DataW+1:0] est;
		if (w < m)
			return '0;
		if (m < cfg_mirror.disconnect_level)
			return w;
		t = w - m;
		if (t > m) begin
			half = t >> 1;
			weakest = (m > half) ? m - half : m >> 1;
		end else begin
			half = m >> 1;
			weakest = (t > half) ? t - half : t >> 1;
		end
		est = {weakest, 2'b00};
		if (est > {2'b00, w})
			est = {2'b00, w};
		else if (est <= {2'b00, cfg_mirror.alkaline_warn_level} &&
				est + {2'b00, NearMargin} > {2'b00, w})
			est = {2'b00, w};
		return est[DataW-1:0];
	endfunction

	// Equivalent battery voltage from one pair of readings
	function automatic logic [DataW-1:0] stack_voltage(input logic [DataW-1:0] whole,
			input logic [DataW-1:0] mid);
		logic [DataW-1:0] w;
		logic [DataW-1:0] m;
		if (whole < cfg_mirror.disconnect_level)
			return whole;
		w = whole + cfg_mirror.offset_full;
		if (mid <= cfg_mirror.disconnect_level)
			return w;
		m = mid + cfg_mirror.offset_mid;
		return weakest_cell_estimate(w, m);
	endfunction

	function automatic status_t grade_level(input logic [DataW-1:0] v);
		if (v > cfg_mirror.low_threshold)
			return STATUS_NORMAL;
		if (v > cfg_mirror.stop_threshold)
			return STATUS_WARNING;
		return STATUS_STOP;
	endfunction

	// Compare results, predict accepted items, then track register writes
	always @(posedge clk or negedge arst_n) begin
		battery_report_t got;
		battery_report_t want;
		logic [DataW-1:0] v;
		if (!arst_n) begin
			cfg_mirror = '0;
			confirm_sum = '0;
			confirm_count = '0;
			predicted_reports.delete();
			pending = 0;
			fail_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = {voltage, status, is_lithium, non_full};
				if (predicted_reports.size() == 0) begin
					$error("result with no item waiting: voltage %0d status %0d",
						voltage, status);
					fail_count++;
				end else begin
					want = predicted_reports.pop_front();
					if (got.voltage !== want.voltage) begin
						$error("voltage: expected %0d, got %0d", want.voltage, got.voltage);
						fail_count++;
					end
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						fail_count++;
					end
					if (got.is_lithium !== want.is_lithium) begin
						$error("is_lithium: expected %0d, got %0d",
							want.is_lithium, got.is_lithium);
						fail_count++;
					end
					if (got.non_full !== want.non_full) begin
						$error("non_full: expected %0d, got %0d", want.non_full, got.non_full);
						fail_count++;
					end
				end
			end

			if (in_valid && in_ready) begin
				v = stack_voltage(whole_reading, mid_reading);
				if (req_t'(req_type) == REQ_SINGLE) begin
					want.voltage = v;
					want.status = grade_level(v);
					if (want.status == STATUS_STOP && v <= cfg_mirror.disconnect_level)
						want.status = STATUS_DISCONNECTED;
					want.is_lithium = (v >= cfg_mirror.lithium_level);
					want.non_full = (v <= cfg_mirror.good_full_level) &&
						(mid_reading > cfg_mirror.disconnect_level);
					predicted_reports.push_back(want);
				end else begin
					// accumulate; the fourth confirm item yields the average
					confirm_sum = confirm_sum + {2'b00, v};
					if (confirm_count != LastSample) begin
						confirm_count = confirm_count + 1'b1;
					end else begin
						want.voltage = DataW'(confirm_sum >> ConfirmShift);
						want.status = grade_level(want.voltage);
						want.is_lithium = 1'b0;
						want.non_full = 1'b0;
						predicted_reports.push_back(want);
						confirm_sum = '0;
						confirm_count = '0;
					end
				end
			end

			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[AddrW-1:2]))
					REG_OFFSET_FULL:    cfg_mirror.offset_full = pwdata[DataW-1:0];
					REG_OFFSET_MID:     cfg_mirror.offset_mid = pwdata[DataW-1:0];
					REG_LOW_THRESHOLD:  cfg_mirror.low_threshold = pwdata[DataW-1:0];
					REG_STOP_THRESHOLD: cfg_mirror.stop_threshold = pwdata[DataW-1:0];
					REG_DISCONNECT:     cfg_mirror.disconnect_level = pwdata[DataW-1:0];
					REG_ALKALINE_WARN:  cfg_mirror.alkaline_warn_level = pwdata[DataW-1:0];
					REG_GOOD_FULL:      cfg_mirror.good_full_level = pwdata[DataW-1:0];
					REG_LITHIUM:        cfg_mirror.lithium_level = pwdata[DataW-1:0];
					default: ;
				endcase
			end

			pending = predicted_reports.size();
		end
	end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// Top of the battery level monitor testbench: clock, reset, register setup,
// directed and random reading pairs, and the verdict.
// Depends on blm_pkg, battery_level_monitor and blm_tb_checker.
module tb_top;
	import blm_pkg::*;

	localparam int Settle = 4;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [AddrW-1:0]  paddr = '0;
	logic [PDataW-1:0] pwdata = '0;
	logic [PDataW-1:0] prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              req_type = 1'b0;
	logic [DataW-1:0]  whole_reading = '0;
	logic [DataW-1:0]  mid_reading = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [DataW-1:0]  voltage;
	logic [1:0]        status;
	logic              is_lithium;
	logic              non_full;
	int                pending;
	int                fail_count;
	bit                calm = 1'b0;
	cfg_t              cur_cfg = '0;

	battery_level_monitor uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
		.whole_reading(whole_reading), .mid_reading(mid_reading),
		.out_valid(out_valid), .out_ready(out_ready), .voltage(voltage),
		.status(status), .is_lithium(is_lithium), .non_full(non_full)
	);

	blm_tb_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
		.whole_reading(whole_reading), .mid_reading(mid_reading),
		.out_valid(out_valid), .out_ready(out_ready), .voltage(voltage),
		.status(status), .is_lithium(is_lithium), .non_full(non_full),
		.pending(pending), .fail_count(fail_count)
	);

	always #1 clk = ~clk;

	// Stall the receiver at random, except during the calm stretch
	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(0, 99) >= 34);
	end

	task automatic write_reg(input reg_idx_t idx, input logic [DataW-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'($urandom), val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_config(input cfg_t c);
		write_reg(REG_OFFSET_FULL, c.offset_full);
		write_reg(REG_OFFSET_MID, c.offset_mid);
		write_reg(REG_LOW_THRESHOLD, c.low_threshold);
		write_reg(REG_STOP_THRESHOLD, c.stop_threshold);
		write_reg(REG_DISCONNECT, c.disconnect_level);
		write_reg(REG_ALKALINE_WARN, c.alkaline_warn_level);
		write_reg(REG_GOOD_FULL, c.good_full_level);
		write_reg(REG_LITHIUM, c.lithium_level);
		cur_cfg = c;
	endtask

	// Offer one item, after a random gap unless calm, and hold it until accepted
	task automatic send_item(input req_t rq, input logic [DataW-1:0] whole,
			input logic [DataW-1:0] mid);
		while (!calm && $urandom_range(0, 99) < 34) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rq;
		whole_reading <= whole;
		mid_reading <= mid;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Drop valid, wait out every expected result and the pipeline tail
	task automatic drain;
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (Settle) @(posedge clk);
	endtask

	function automatic cfg_t random_config(input bit realistic);
		cfg_t c;
		c = {8{16'($urandom)}};
		c = {$urandom, $urandom, $urandom, $urandom};
		if (realistic) begin
			c.offset_full = 16'($urandom_range(0, 400));
			c.offset_mid = 16'($urandom_range(0, 400));
			c.disconnect_level = 16'($urandom_range(0, 6000));
			c.stop_threshold = 16'($urandom_range(5000, 35000));
			c.low_threshold = c.stop_threshold + 16'($urandom_range(0, 20000));
			c.good_full_level = 16'($urandom_range(20000, 65535));
			c.lithium_level = 16'($urandom_range(20000, 65535));
		end
		return c;
	endfunction

	// Mostly mid readings near half the stack, so every estimate branch is hit
	task automatic random_readings(output logic [DataW-1:0] whole,
			output logic [DataW-1:0] mid);
		int unsigned pick;
		int noise;
		pick = $urandom_range(0, 9);
		whole = 16'($urandom);
		if (pick < 2) begin
			mid = 16'($urandom);
		end else if (pick == 2) begin
			mid = 16'($urandom_range(0, cur_cfg.disconnect_level));
		end else begin
			noise = int'($urandom_range(0, 6000)) - 3000;
			mid = 16'(int'(whole >> 1) + noise);
		end
		if (pick == 9)
			whole = 16'($urandom_range(0, cur_cfg.disconnect_level));
	endtask

	initial begin
		cfg_t c;
		logic [DataW-1:0] w;
		logic [DataW-1:0] m;
		req_t rq;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers at reset values
		send_item(REQ_SINGLE, 16'h0000, 16'h0000);
		send_item(REQ_SINGLE, 16'hFFFF, 16'hFFFF);
		send_item(REQ_SINGLE, 16'hFFFF, 16'h0000);
		drain();

		// typical thresholds, one item per estimate path and status level
		c.offset_full = 16'd100;
		c.offset_mid = 16'd50;
		c.low_threshold = 16'd40000;
		c.stop_threshold = 16'd30000;
		c.disconnect_level = 16'd2000;
		c.alkaline_warn_level = 16'd36000;
		c.good_full_level = 16'd48000;
		c.lithium_level = 16'd52000;
		load_config(c);
		send_item(REQ_SINGLE, 16'd1500, 16'd700);     // whole below disconnect: raw
		send_item(REQ_SINGLE, 16'd45000, 16'd1000);   // mid absent
		send_item(REQ_SINGLE, 16'd10000, 16'd30000);  // whole under mid: zero
		send_item(REQ_SINGLE, 16'd20000, 16'd65500);  // mid wraps below disconnect
		send_item(REQ_SINGLE, 16'd29900, 16'd11950);  // upper half large, mid wins
		send_item(REQ_SINGLE, 16'd39900, 16'd9950);   // upper half large, half mid
		send_item(REQ_SINGLE, 16'd49900, 16'd25950);  // lower half large
		send_item(REQ_SINGLE, 16'd49900, 16'd39950);  // lower half small
		send_item(REQ_SINGLE, 16'd4002, 16'd2001);    // estimate above whole: clamp
		send_item(REQ_SINGLE, 16'd19900, 16'd10050);  // close to whole near alkaline
		send_item(REQ_SINGLE, 16'd34900, 16'd0);      // warning
		send_item(REQ_SINGLE, 16'd59900, 16'd2000);   // lithium, mid at disconnect
		send_item(REQ_SINGLE, 16'd2000, 16'd0);       // whole at disconnect level
		// confirm average with a single request in between
		send_item(REQ_CONFIRM, 16'd39900, 16'd0);
		send_item(REQ_SINGLE, 16'd45000, 16'd20000);
		send_item(REQ_CONFIRM, 16'd29900, 16'd0);
		send_item(REQ_CONFIRM, 16'd34900, 16'd0);
		send_item(REQ_CONFIRM, 16'd44900, 16'd0);
		drain();

		// every register at its maximum
		load_config({8{16'hFFFF}});
		send_item(REQ_SINGLE, 16'hFFFF, 16'hFFFF);
		send_item(REQ_SINGLE, 16'h0000, 16'hFFFF);
		drain();

		// random phases over several settings
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				1: c = '0;
				2: c = random_config(1'b0);
				4: begin
					c = random_config(1'b1);
					c.offset_full = 16'hFFFF;
					c.offset_mid = 16'hFFFF;
				end
				default: c = random_config(1'b1);
			endcase
			load_config(c);
			for (int n = 0; n < 238; n++) begin
				calm = (phase == 3 && n < 200);
				rq = ($urandom_range(0, 99) < 40) ? REQ_CONFIRM : REQ_SINGLE;
				random_readings(w, m);
				send_item(rq, w, m);
			end
			calm = 1'b0;
			drain();
		end

		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#400000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ battery_level_monitor.f @@
sv/blm_pkg.sv
sv/blm_regs.sv
sv/blm_estimate.sv
sv/blm_result.sv
sv/battery_level_monitor.sv
sv/blm_checker.sv
test/blm_checker.sv
test/tb_top.sv
